/* hw/rtl/oadp_pkg.sv */
// Shared types, constants and lookup functions for the obstacle-avoid move picker.
// Depends on nothing; every other file imports it.
package oadp_pkg;

   localparam int DIST_W   = 8;
   localparam int MOM_W    = 15;
   localparam int HIT_W    = 5;
   localparam int WEIGHT_W = 15;
   localparam int DECAY_W  = 17;
   localparam int MUL_A_W  = 19;
   localparam int MUL_B_W  = 17;
   localparam int MUL_P_W  = 36;
   localparam int SCORE_W  = 31;
   localparam int QUOT_W   = 17;
   localparam int STUCK_W  = 2;
   localparam int CAND_W   = 4;

   typedef logic [DIST_W-1:0]  dist_type;
   typedef logic [MOM_W-1:0]   mom_type;
   typedef logic [HIT_W-1:0]   hit_type;
   typedef logic [SCORE_W-1:0] score_type;

   typedef enum logic [3:0] {
      MV_N    = 4'd0,
      MV_S    = 4'd1,
      MV_E    = 4'd2,
      MV_W    = 4'd3,
      MV_NE   = 4'd4,
      MV_NW   = 4'd5,
      MV_SE   = 4'd6,
      MV_SW   = 4'd7,
      MV_STOP = 4'd8
   } move_type;

   typedef enum logic [0:0] {
      CSR_OBSTACLE_THRESHOLD = 1'b0,
      CSR_STOP_LIMIT         = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_JUDGE,
      ST_SCORE,
      ST_MOM_MUL,
      ST_MOM_FIX,
      ST_DONE
   } state_type;

   localparam mom_type MOM_ONE = 15'd16384;
   localparam mom_type MOM_MAX = 15'd24576;
   localparam mom_type MOM_MIN = 15'd8192;

   // floor(x/10) for x < 2^19 is (x*RECIP_10) >> RECIP_SHIFT, at most one too high
   localparam logic [MUL_B_W-1:0] RECIP_10    = 17'd52429;
   localparam int                 RECIP_SHIFT = 19;

   localparam int                 DIFF_LIMIT  = 6;
   localparam logic [STUCK_W-1:0] STUCK_LAST  = 2'd3;
   localparam logic [CAND_W-1:0]  CAND_END    = 4'd8;

   typedef struct packed {
      logic     scan_start;
      logic     scan_en;
      logic     wr_en;
      logic     clr_fill;
      move_type wr_move;
   } hist_ctrl_type;

   typedef struct packed {
      logic [7:0][HIT_W-1:0] hits;
      logic                  stuck;
      logic                  scan_last;
   } hist_stat_type;

   // Candidate order: N NE NW E W SE SW S
   function automatic move_type try_move(input logic [2:0] k);
      move_type mv;
      case (k)
         3'd0: mv = MV_N;
         3'd1: mv = MV_NE;
         3'd2: mv = MV_NW;
         3'd3: mv = MV_E;
         3'd4: mv = MV_W;
         3'd5: mv = MV_SE;
         3'd6: mv = MV_SW;
         3'd7: mv = MV_S;
         default: mv = MV_N;
      endcase
      return mv;
   endfunction

   // Weights are 20x the real ones; north carries its 1.5 preference
   function automatic logic [WEIGHT_W-1:0] base_weight(input move_type mv,
                                                       input dist_type f,
                                                       input dist_type b,
                                                       input dist_type l,
                                                       input dist_type r);
      logic [WEIGHT_W-1:0] fw;
      logic [WEIGHT_W-1:0] bw;
      logic [WEIGHT_W-1:0] lw;
      logic [WEIGHT_W-1:0] rw;
      logic [WEIGHT_W-1:0] w;
      fw = WEIGHT_W'(f);
      bw = WEIGHT_W'(b);
      lw = WEIGHT_W'(l);
      rw = WEIGHT_W'(r);
      case (mv)
         MV_N:    w = fw * 15'd75;
         MV_S:    w = bw * 15'd10;
         MV_E:    w = rw * 15'd24;
         MV_W:    w = lw * 15'd24;
         MV_NE:   w = fw * 15'd18 + rw * 15'd15;
         MV_NW:   w = fw * 15'd18 + lw * 15'd15;
         MV_SE:   w = bw * 15'd6 + rw * 15'd8;
         MV_SW:   w = bw * 15'd6 + lw * 15'd8;
         default: w = '0;
      endcase
      return w;
   endfunction

   // 0.85^h in Q1.16, rounded to nearest
   function automatic logic [DECAY_W-1:0] decay_q16(input hit_type h);
      logic [DECAY_W-1:0] d;
      case (h)
         5'd0:    d = 17'd65536;
         5'd1:    d = 17'd55706;
         5'd2:    d = 17'd47350;
         5'd3:    d = 17'd40247;
         5'd4:    d = 17'd34210;
         5'd5:    d = 17'd29079;
         5'd6:    d = 17'd24717;
         5'd7:    d = 17'd21009;
         5'd8:    d = 17'd17858;
         5'd9:    d = 17'd15179;
         5'd10:   d = 17'd12902;
         5'd11:   d = 17'd10967;
         5'd12:   d = 17'd9322;
         5'd13:   d = 17'd7924;
         5'd14:   d = 17'd6735;
         5'd15:   d = 17'd5725;
         default: d = 17'd4866;
      endcase
      return d;
   endfunction

endpackage

/* hw/rtl/oadp_intf.sv */
// Valid/ready channel interfaces of the move picker: readings in, moves out, register writes.
// Depends on oadp_pkg.
interface oadp_req_if import oadp_pkg::*; ();
   logic     valid;
   logic     ready;
   dist_type front_distance;
   dist_type back_distance;
   dist_type left_distance;
   dist_type right_distance;

   modport source (output valid, front_distance, back_distance, left_distance,
                   right_distance, input ready);
   modport sink   (input valid, front_distance, back_distance, left_distance,
                   right_distance, output ready);
endinterface

interface oadp_rsp_if import oadp_pkg::*; ();
   logic     valid;
   logic     ready;
   move_type move_dir;
   logic     escaped;
   logic     none_safe;
   mom_type  momentum_out;

   modport source (output valid, move_dir, escaped, none_safe, momentum_out,
                   input ready);
   modport sink   (input valid, move_dir, escaped, none_safe, momentum_out,
                   output ready);
endinterface

interface oadp_csr_if import oadp_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   dist_type    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

/* hw/rtl/oadp_mul.sv */
// Shared multiplier of the move picker with a registered product.
// Depends on oadp_pkg.
module oadp_mul import oadp_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(a) * MUL_P_W'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

/* hw/rtl/oadp_hist.sv */
// Move history ring with a scan, one entry per cycle while scan_en is high, that counts hits per move,
// backward moves and entries unlike slot 0. Depends on oadp_pkg.
module oadp_hist import oadp_pkg::*; #(
   parameter int HISTORY_DEPTH = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  hist_ctrl_type ctrl,
   output hist_stat_type stat
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL       = CNT_W'(HISTORY_DEPTH);
   localparam hit_type          BACK_LIMIT = HIT_W'(HISTORY_DEPTH / 2);
   localparam hit_type          DIFF_LIM   = HIT_W'(DIFF_LIMIT);

   move_type         mem_ff  [HISTORY_DEPTH];
   move_type         mem_in  [HISTORY_DEPTH];
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   hit_type          hits_ff [8];
   hit_type          hits_in [8];
   hit_type          back_ff, back_in;
   hit_type          diff_ff, diff_in;
   move_type         rd;
   logic             in_fill;
   logic             is_back;

   always_comb begin
      rd      = mem_ff[idx_ff];
      in_fill = CNT_W'(idx_ff) < fill_ff;
      is_back = (rd == MV_S) || (rd == MV_SE) || (rd == MV_SW);

      for (int j = 0; j < 8; j++) begin
         if (ctrl.scan_start) begin
            hits_in[j] = '0;
         end else if (ctrl.scan_en && in_fill && rd == move_type'(j)) begin
            hits_in[j] = hits_ff[j] + 1'b1;
         end else begin
            hits_in[j] = hits_ff[j];
         end
      end

      back_in = back_ff;
      diff_in = diff_ff;
      idx_in  = idx_ff;
      if (ctrl.scan_start) begin
         back_in = '0;
         diff_in = '0;
         idx_in  = '0;
      end else if (ctrl.scan_en) begin
         back_in = back_ff + HIT_W'(is_back);
         diff_in = diff_ff + HIT_W'(rd != mem_ff[0]);
         idx_in  = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end

      for (int e = 0; e < HISTORY_DEPTH; e++) begin
         mem_in[e] = (ctrl.wr_en && slot_ff == IDX_W'(e)) ? ctrl.wr_move : mem_ff[e];
      end

      slot_in = slot_ff;
      fill_in = fill_ff;
      if (ctrl.clr_fill) begin
         slot_in = '0;
         fill_in = '0;
      end else if (ctrl.wr_en) begin
         slot_in = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
         fill_in = (fill_ff == FULL) ? fill_ff : fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < HISTORY_DEPTH; e++) begin
            mem_ff[e] <= MV_N;
         end
         fill_ff <= '0;
         slot_ff <= '0;
         idx_ff  <= '0;
      end else begin
         mem_ff  <= mem_in;
         fill_ff <= fill_in;
         slot_ff <= slot_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hits_ff <= hits_in;
      back_ff <= back_in;
      diff_ff <= diff_in;
   end

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         stat.hits[j] = hits_ff[j];
      end
      stat.stuck     = (fill_ff == FULL) && ((back_ff > BACK_LIMIT) || (diff_ff > DIFF_LIM));
      stat.scan_last = (idx_ff == LAST_IDX);
   end

endmodule

/* hw/rtl/obstacle_avoid_direction_pick.sv */
// Obstacle-avoid move picker: top level with the sequencer, scoring and momentum.
// Depends on oadp_pkg, oadp_intf, oadp_hist and oadp_mul.
//
// Each transfer on req_chan carries four distance readings; the block answers with one
// transfer on rsp_chan giving one of nine moves (N S E W NE NW SE SW STOP), an escape flag,
// a no-safe-move flag and the updated Q1.14 momentum. One item is in work at a time and
// req_chan.ready is high only while the sequencer idles. An item that finds all four readings
// under the stop limit goes straight to the done state with its STOP result. Every other item
// first scans the move history, one entry a cycle; a stuck escape then goes to the done state.
// A scored item runs its eight candidates and then the momentum divide-by-ten through the
// one shared multiplier. From the done state a result moves into the output register once
// that is free. A finished result waits in the output register while the next item is
// taken. Registers are written on csr_chan (always ready); the user must write them only
// while the block is idle, as the block itself does not enforce this.
module obstacle_avoid_direction_pick import oadp_pkg::*; #(
   parameter int HISTORY_DEPTH = 10
) (
   input  logic      clock,
   input  logic      reset,
   oadp_req_if.sink   req_chan,
   oadp_rsp_if.source rsp_chan,
   oadp_csr_if.sink   csr_chan
);

   // ---------------------------------------------------------------------------------
   // Declarations
   // ---------------------------------------------------------------------------------
   state_type          state_ff, state_in;

   dist_type           thr_ff, thr_in;
   dist_type           crit_ff, crit_in;
   dist_type           f_ff, f_in, b_ff, b_in, l_ff, l_in, r_ff, r_in;
   logic [STUCK_W-1:0] stuck_ff, stuck_in;
   mom_type            mom_ff, mom_in;

   logic [CAND_W-1:0]  k_ff, k_in;
   logic               pvalid_ff, pvalid_in;
   logic               psafe_ff, psafe_in;
   logic               found_safe_ff, found_safe_in;
   logic               found_all_ff, found_all_in;
   score_type          best_safe_ff, best_safe_in;
   score_type          best_all_ff, best_all_in;
   move_type           safe_mv_ff, safe_mv_in;
   move_type           all_mv_ff, all_mv_in;
   logic [MUL_A_W-1:0] x_ff, x_in;

   move_type           res_dir_ff, res_dir_in;
   logic               res_esc_ff, res_esc_in;
   logic               res_ns_ff, res_ns_in;
   mom_type            res_mom_ff, res_mom_in;

   logic               rsp_valid_ff, rsp_valid_in;
   move_type           rsp_dir_ff, rsp_dir_in;
   logic               rsp_esc_ff, rsp_esc_in;
   logic               rsp_ns_ff, rsp_ns_in;
   mom_type            rsp_mom_ff, rsp_mom_in;

   hist_ctrl_type      hctrl;
   hist_stat_type      hstat;
   logic               mul_en;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;

   logic               req_fire;
   logic               csr_fire;
   logic               is_stop;
   logic               escape;
   logic               out_free;
   logic               fs, bs, ls, rs;
   move_type           cand_now;
   move_type           cand_ff, cand_in;
   move_type           esc_dir;
   move_type           chosen;
   dist_type           far1, far2;
   score_type          score_now;
   logic [MUL_A_W-1:0] x_now;
   logic [MUL_A_W-1:0] mom_wide;
   logic [QUOT_W-1:0]  q0;
   logic [QUOT_W-1:0]  quot;
   logic [QUOT_W+3:0]  q0_x10;
   mom_type            mom_clamped;

   function automatic logic move_safe(input move_type mv, input logic sf, input logic sb,
                                      input logic sl, input logic sr);
      logic s;
      case (mv)
         MV_N:    s = sf;
         MV_S:    s = sb;
         MV_E:    s = sr;
         MV_W:    s = sl;
         MV_NE:   s = sf && sr;
         MV_NW:   s = sf && sl;
         MV_SE:   s = sb && sr;
         MV_SW:   s = sb && sl;
         default: s = 1'b0;
      endcase
      return s;
   endfunction

   // ---------------------------------------------------------------------------------
   // Submodules: history ring/scan and the shared multiplier
   // ---------------------------------------------------------------------------------
   oadp_hist #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock (clock),
      .reset (reset),
      .ctrl  (hctrl),
      .stat  (hstat)
   );

   oadp_mul u_mul (
      .clock   (clock),
      .en      (mul_en),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p)
   );

   // ---------------------------------------------------------------------------------
   // Handshake and decode terms
   // ---------------------------------------------------------------------------------
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // STOP when every reading is strictly under the stop limit
   assign is_stop = (req_chan.front_distance < crit_ff) && (req_chan.back_distance < crit_ff)
                 && (req_chan.left_distance < crit_ff) && (req_chan.right_distance < crit_ff);

   // Fourth stuck hit since the last escape forces the escape
   assign escape = hstat.stuck && (stuck_ff == STUCK_LAST);

   assign fs = f_ff > thr_ff;
   assign bs = b_ff > thr_ff;
   assign ls = l_ff > thr_ff;
   assign rs = r_ff > thr_ff;

   assign cand_now  = try_move(k_ff[2:0]);
   assign score_now = mul_p[SCORE_W-1:0];
   assign chosen    = found_safe_ff ? safe_mv_ff : all_mv_ff;

   // Farthest cardinal side; ties keep the earlier of N, S, W, E
   always_comb begin
      esc_dir = MV_N;
      far1    = f_ff;
      if (b_ff > far1) begin
         esc_dir = MV_S;
         far1    = b_ff;
      end
      far2 = far1;
      if (l_ff > far2) begin
         esc_dir = MV_W;
         far2    = l_ff;
      end
      if (r_ff > far2) begin
         esc_dir = MV_E;
      end
   end

   // Momentum: (m*11+5)/10 after north, (m*9+5)/10 otherwise; the quotient from the
   // reciprocal product is at most one too high, so correct it with one compare
   always_comb begin
      mom_wide = MUL_A_W'(mom_ff);
      x_now    = (chosen == MV_N) ? mom_wide * 19'd11 + 19'd5 : mom_wide * 19'd9 + 19'd5;
      q0       = mul_p[RECIP_SHIFT +: QUOT_W];
      q0_x10   = (QUOT_W + 4)'(q0) * 21'd10;
      quot     = (q0_x10 > (QUOT_W + 4)'(x_ff)) ? q0 - 1'b1 : q0;
      if (res_dir_ff == MV_N) begin
         mom_clamped = (quot > QUOT_W'(MOM_MAX)) ? MOM_MAX : quot[MOM_W-1:0];
      end else begin
         mom_clamped = (quot < QUOT_W'(MOM_MIN)) ? MOM_MIN : quot[MOM_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = is_stop ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hstat.scan_last) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            state_in = escape ? ST_DONE : ST_SCORE;
         end
         ST_SCORE: begin
            if (k_ff == CAND_END) begin
               state_in = ST_MOM_MUL;
            end
         end
         ST_MOM_MUL: begin
            state_in = ST_MOM_FIX;
         end
         ST_MOM_FIX: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Sequencer: control outputs
   // ---------------------------------------------------------------------------------
   always_comb begin
      req_chan.ready   = 1'b0;
      hctrl.scan_start = 1'b0;
      hctrl.scan_en    = 1'b0;
      hctrl.wr_en      = 1'b0;
      hctrl.clr_fill   = 1'b0;
      hctrl.wr_move    = chosen;
      mul_en           = 1'b0;
      mul_a            = x_now;
      mul_b            = RECIP_10;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready   = 1'b1;
            hctrl.scan_start = req_fire;
         end
         ST_SCAN: begin
            hctrl.scan_en = 1'b1;
         end
         ST_JUDGE: begin
            hctrl.clr_fill = escape;
         end
         ST_SCORE: begin
            // one candidate into the multiplier per cycle
            mul_en = (k_ff != CAND_END);
            mul_a  = MUL_A_W'(base_weight(cand_now, f_ff, b_ff, l_ff, r_ff));
            mul_b  = decay_q16(hstat.hits[cand_now[2:0]]);
         end
         ST_MOM_MUL: begin
            mul_en      = 1'b1;
            hctrl.wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------------------
   always_comb begin
      thr_in        = thr_ff;
      crit_in       = crit_ff;
      f_in          = f_ff;
      b_in          = b_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      stuck_in      = stuck_ff;
      mom_in        = mom_ff;
      k_in          = k_ff;
      pvalid_in     = 1'b0;
      psafe_in      = psafe_ff;
      cand_in       = cand_ff;
      found_safe_in = found_safe_ff;
      found_all_in  = found_all_ff;
      best_safe_in  = best_safe_ff;
      best_all_in   = best_all_ff;
      safe_mv_in    = safe_mv_ff;
      all_mv_in     = all_mv_ff;
      x_in          = x_ff;
      res_dir_in    = res_dir_ff;
      res_esc_in    = res_esc_ff;
      res_ns_in     = res_ns_ff;
      res_mom_in    = res_mom_ff;

      if (csr_fire) begin
         case (csr_chan.index)
            CSR_OBSTACLE_THRESHOLD: thr_in  = csr_chan.wdata;
            CSR_STOP_LIMIT:         crit_in = csr_chan.wdata;
            default: begin
            end
         endcase
      end

      // compare stage: the product of the previous candidate is in the multiplier
      if (pvalid_ff) begin
         if (psafe_ff && (!found_safe_ff || score_now > best_safe_ff)) begin
            found_safe_in = 1'b1;
            best_safe_in  = score_now;
            safe_mv_in    = cand_ff;
         end
         if (!found_all_ff || score_now > best_all_ff) begin
            found_all_in = 1'b1;
            best_all_in  = score_now;
            all_mv_in    = cand_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               f_in       = req_chan.front_distance;
               b_in       = req_chan.back_distance;
               l_in       = req_chan.left_distance;
               r_in       = req_chan.right_distance;
               res_dir_in = MV_STOP;
               res_esc_in = 1'b0;
               res_ns_in  = 1'b0;
               res_mom_in = mom_ff;
            end
         end
         ST_JUDGE: begin
            k_in          = '0;
            found_safe_in = 1'b0;
            found_all_in  = 1'b0;
            if (hstat.stuck) begin
               stuck_in = escape ? '0 : stuck_ff + 1'b1;
            end
            if (escape) begin
               res_dir_in = esc_dir;
               res_esc_in = 1'b1;
               res_ns_in  = 1'b0;
               res_mom_in = mom_ff;
            end
         end
         ST_SCORE: begin
            if (k_ff != CAND_END) begin
               k_in      = k_ff + 1'b1;
               pvalid_in = 1'b1;
               cand_in   = cand_now;
               psafe_in  = move_safe(cand_now, fs, bs, ls, rs);
            end
         end
         ST_MOM_MUL: begin
            x_in       = x_now;
            res_dir_in = chosen;
            res_esc_in = 1'b0;
            res_ns_in  = !found_safe_ff;
         end
         ST_MOM_FIX: begin
            mom_in     = mom_clamped;
            res_mom_in = mom_clamped;
         end
         default: begin
         end
      endcase
   end

   // Output register: load when the slot is free, drop valid after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_dir_in   = rsp_dir_ff;
      rsp_esc_in   = rsp_esc_ff;
      rsp_ns_in    = rsp_ns_ff;
      rsp_mom_in   = rsp_mom_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_dir_in   = res_dir_ff;
         rsp_esc_in   = res_esc_ff;
         rsp_ns_in    = res_ns_ff;
         rsp_mom_in   = res_mom_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= 8'd25;
         crit_ff      <= 8'd15;
         stuck_ff     <= '0;
         mom_ff       <= MOM_ONE;
         k_ff         <= '0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         crit_ff      <= crit_in;
         stuck_ff     <= stuck_in;
         mom_ff       <= mom_in;
         k_ff         <= k_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff          <= f_in;
      b_ff          <= b_in;
      l_ff          <= l_in;
      r_ff          <= r_in;
      psafe_ff      <= psafe_in;
      cand_ff       <= cand_in;
      found_safe_ff <= found_safe_in;
      found_all_ff  <= found_all_in;
      best_safe_ff  <= best_safe_in;
      best_all_ff   <= best_all_in;
      safe_mv_ff    <= safe_mv_in;
      all_mv_ff     <= all_mv_in;
      x_ff          <= x_in;
      res_dir_ff    <= res_dir_in;
      res_esc_ff    <= res_esc_in;
      res_ns_ff     <= res_ns_in;
      res_mom_ff    <= res_mom_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_esc_ff    <= rsp_esc_in;
      rsp_ns_ff     <= rsp_ns_in;
      rsp_mom_ff    <= rsp_mom_in;
   end

   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.move_dir     = rsp_dir_ff;
   assign rsp_chan.escaped      = rsp_esc_ff;
   assign rsp_chan.none_safe    = rsp_ns_ff;
   assign rsp_chan.momentum_out = rsp_mom_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------

   // Momentum stays inside its clamp window
   a_mom_range: assert property (@(posedge clock) disable iff (reset)
      (mom_ff >= MOM_MIN) && (mom_ff <= MOM_MAX))
      else $error("momentum left its clamp window");

   // Escape and fallback scoring never flag the same result
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.escaped && rsp_chan.none_safe))
      else $error("escaped and none_safe both set");

   // STOP carries neither flag
   a_stop_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.move_dir == MV_STOP) |->
         (!rsp_chan.escaped && !rsp_chan.none_safe))
      else $error("STOP result with a flag set");

   // One item at a time: no new transfer the cycle after one is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("input taken while an item is in work");

endmodule

/* test/obstacle_avoid_direction_pick_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for obstacle_avoid_direction_pick: predicts each move in step
// with the block and checks every result transfer. Depends on oadp_pkg, oadp_intf and the RTL.
module obstacle_avoid_direction_pick_tb;
   import oadp_pkg::*;

   localparam int HIST_DEPTH      = 10;
   localparam int DIVERSE_LIMIT   = 6;
   localparam int STUCK_ESCAPE_AT = 3;
   localparam int MOMENTUM_RESET  = 16384;
   localparam int MOMENTUM_CEIL   = 24576;
   localparam int MOMENTUM_FLOOR  = 8192;
   localparam int SETTLE_CYCLES   = 30;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int PRINT_LIMIT     = 60;

   typedef struct {
      move_type move_dir;
      logic     escaped;
      logic     none_safe;
      mom_type  momentum_out;
   } pick_result_type;

   // Shapes of random readings; runs of one shape drive the history into its corners
   typedef enum int {
      MIX_UNIFORM,
      MIX_BACKWARD,
      MIX_FORWARD,
      MIX_SIDES,
      MIX_EDGE,
      MIX_BLOCKED
   } reading_mix_type;

   logic clock;
   logic reset;

   oadp_req_if req_chan ();
   oadp_rsp_if rsp_chan ();
   oadp_csr_if csr_chan ();

   obstacle_avoid_direction_pick #(
      .HISTORY_DEPTH(HIST_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // ---------------------------------------------------------------------------------
   // Predictor state: move history, fill and write pointers, stuck counter, momentum,
   // and the two register copies.
   // ---------------------------------------------------------------------------------
   move_type    hist_q [HIST_DEPTH];
   int unsigned fill_n;
   int unsigned slot_n;
   int unsigned stuck_n;
   logic [15:0] mom_q;
   dist_type    thresh_q;
   dist_type    crit_q;

   // 0.85^hits in Q1.16, rounded to nearest
   int unsigned decay_tab [0:16] = '{65536, 55706, 47350, 40247, 34210, 29079, 24717,
                                      21009, 17858, 15179, 12902, 10967, 9322, 7924,
                                      6735, 5725, 4866};

   // Candidates are tried in this order; a later one needs a strictly higher score
   move_type cand_order [0:7] = '{MV_N, MV_NE, MV_NW, MV_E, MV_W, MV_SE, MV_SW, MV_S};

   pick_result_type pending_moves [$];

   int err_count;
   int cycle_count;
   int hold_rsp_cycles;
   bit tx_idle_en;
   bit rx_idle_en;

   function automatic void clear_predictor();
      foreach (hist_q[i]) hist_q[i] = MV_N;
      fill_n   = 0;
      slot_n   = 0;
      stuck_n  = 0;
      mom_q    = 16'(MOMENTUM_RESET);
      thresh_q = 8'd25;
      crit_q   = 8'd15;
   endfunction

   function automatic bit move_is_safe(input move_type mv, input dist_type f,
                                       input dist_type b, input dist_type l,
                                       input dist_type r);
      bit fs;
      bit bs;
      bit ls;
      bit rs;
      fs = f > thresh_q;
      bs = b > thresh_q;
      ls = l > thresh_q;
      rs = r > thresh_q;
      case (mv)
         MV_N:    return fs;
         MV_S:    return bs;
         MV_E:    return rs;
         MV_W:    return ls;
         MV_NE:   return fs && rs;
         MV_NW:   return fs && ls;
         MV_SE:   return bs && rs;
         MV_SW:   return bs && ls;
         default: return 1'b0;
      endcase
   endfunction

   // Weight (20x real, north with its preference) times the decay of repeats in history
   function automatic longint unsigned move_score_of(input move_type mv, input dist_type f,
                                                    input dist_type b, input dist_type l,
                                                    input dist_type r);
      int unsigned fw;
      int unsigned bw;
      int unsigned lw;
      int unsigned rw;
      int unsigned w;
      int unsigned hits;
      fw = 32'(f);
      bw = 32'(b);
      lw = 32'(l);
      rw = 32'(r);
      case (mv)
         MV_N:    w = 75 * fw;
         MV_S:    w = 10 * bw;
         MV_E:    w = 24 * rw;
         MV_W:    w = 24 * lw;
         MV_NE:   w = 18 * fw + 15 * rw;
         MV_NW:   w = 18 * fw + 15 * lw;
         MV_SE:   w = 6 * bw + 8 * rw;
         MV_SW:   w = 6 * bw + 8 * lw;
         default: w = 0;
      endcase
      hits = 0;
      for (int i = 0; i < HIST_DEPTH; i++)
         if (i < fill_n && hist_q[i] == mv) hits++;
      if (hits > 16) hits = 16;
      return 64'(w) * 64'(decay_tab[hits]);
   endfunction

   // Work out the move for one set of readings and advance the predictor state
   function automatic pick_result_type pick_move(input dist_type f, input dist_type b,
                                                 input dist_type l, input dist_type r);
      pick_result_type  res;
      int unsigned      back_n;
      int unsigned      diff_n;
      bit               found;
      move_type         best;
      move_type         mv;
      longint unsigned  s;
      longint unsigned  best_s;
      int unsigned      m;
      dist_type         far_d;

      res.escaped   = 1'b0;
      res.none_safe = 1'b0;

      // Boxed in on all four sides: stop and touch nothing
      if (f < crit_q && b < crit_q && l < crit_q && r < crit_q) begin
         res.move_dir     = MV_STOP;
         res.momentum_out = mom_q[14:0];
         return res;
      end

      // Stuck test runs only on a full history
      if (fill_n == HIST_DEPTH) begin
         back_n = 0;
         diff_n = 0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            if (hist_q[i] == MV_S || hist_q[i] == MV_SE || hist_q[i] == MV_SW) back_n++;
            if (hist_q[i] != hist_q[0]) diff_n++;
         end
         if (back_n > HIST_DEPTH / 2 || diff_n > DIVERSE_LIMIT) begin
            stuck_n++;
            if (stuck_n > STUCK_ESCAPE_AT) begin
               // Escape toward the farthest side, ties kept in N S W E order
               stuck_n = 0;
               fill_n  = 0;
               slot_n  = 0;
               far_d   = f;
               mv      = MV_N;
               if (b > far_d) begin far_d = b; mv = MV_S; end
               if (l > far_d) begin far_d = l; mv = MV_W; end
               if (r > far_d) begin far_d = r; mv = MV_E; end
               res.move_dir     = mv;
               res.escaped      = 1'b1;
               res.momentum_out = mom_q[14:0];
               return res;
            end
         end
      end

      found  = 1'b0;
      best   = MV_N;
      best_s = 0;
      foreach (cand_order[k]) begin
         mv = cand_order[k];
         if (move_is_safe(mv, f, b, l, r)) begin
            s = move_score_of(mv, f, b, l, r);
            if (!found || s > best_s) begin
               best_s = s;
               best   = mv;
               found  = 1'b1;
            end
         end
      end
      // Nothing safe: score every move
      if (!found) begin
         res.none_safe = 1'b1;
         foreach (cand_order[k]) begin
            mv = cand_order[k];
            s  = move_score_of(mv, f, b, l, r);
            if (!found || s > best_s) begin
               best_s = s;
               best   = mv;
               found  = 1'b1;
            end
         end
      end

      if (slot_n >= HIST_DEPTH) slot_n = 0;
      hist_q[slot_n] = best;
      slot_n = (slot_n + 1) % HIST_DEPTH;
      if (fill_n < HIST_DEPTH) fill_n++;

      if (best == MV_N) begin
         m = (32'(mom_q) * 11 + 5) / 10;
         if (m > MOMENTUM_CEIL) m = MOMENTUM_CEIL;
      end else begin
         m = (32'(mom_q) * 9 + 5) / 10;
         if (m < MOMENTUM_FLOOR) m = MOMENTUM_FLOOR;
      end
      mom_q = 16'(m);

      res.move_dir     = best;
      res.momentum_out = mom_q[14:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------------------
   // Clock, watchdog and the receiver
   // ---------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a run that hangs; the limit is several times the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("obstacle_avoid_direction_pick_tb: errors");
         $finish;
      end
   end

   // Receiver: a long hold when asked for one, otherwise random stall bursts while rx_idle_en is set
   initial begin
      int n;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp_cycles > 0) begin
            n = hold_rsp_cycles;
            hold_rsp_cycles = 0;
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rx_idle_en && $urandom_range(0, 15) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic report_field(input string name, input int want, input int got);
      err_count++;
      if (err_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
   endtask

   // Check every result transfer against the oldest pending move
   always @(posedge clock) begin : result_check
      pick_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_moves.size() == 0) begin
            err_count++;
            if (err_count <= PRINT_LIMIT)
               $display("%0t: result with nothing pending, expected none actual move %0d",
                        $time, rsp_chan.move_dir);
         end else begin
            want = pending_moves.pop_front();
            if (rsp_chan.move_dir !== want.move_dir)
               report_field("move_dir", want.move_dir, rsp_chan.move_dir);
            if (rsp_chan.escaped !== want.escaped)
               report_field("escaped", want.escaped, rsp_chan.escaped);
            if (rsp_chan.none_safe !== want.none_safe)
               report_field("none_safe", want.none_safe, rsp_chan.none_safe);
            if (rsp_chan.momentum_out !== want.momentum_out)
               report_field("momentum_out", want.momentum_out, rsp_chan.momentum_out);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------

   // Offer one set of readings and hold it until the transfer; valid stays high between
   // back-to-back items.
   task automatic send_reading(input dist_type f, input dist_type b,
                               input dist_type l, input dist_type r);
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.front_distance <= f;
      req_chan.back_distance  <= b;
      req_chan.left_distance  <= l;
      req_chan.right_distance <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_moves.push_back(pick_move(f, b, l, r));
   endtask

   // Hold the register write until it is taken; the caller drops valid
   task automatic write_register(input csr_idx_type idx, input dist_type value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_OBSTACLE_THRESHOLD: thresh_q = value;
         CSR_STOP_LIMIT:         crit_q   = value;
         default: ;
      endcase
   endtask

   // Drain the block, let it settle, then write both registers
   task automatic apply_settings(input dist_type thr, input dist_type crit);
      req_chan.valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_OBSTACLE_THRESHOLD, thr);
      write_register(CSR_STOP_LIMIT, crit);
      csr_chan.valid <= 1'b0;
   endtask

   // A value close to one of the two register edges, clamped to the field range
   function automatic dist_type near_edge();
      int v;
      v = $urandom_range(0, 1) ? int'(thresh_q) : int'(crit_q);
      v = v + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return dist_type'(v);
   endfunction

   function automatic void draw_reading(input reading_mix_type mix, output dist_type f,
                                        output dist_type b, output dist_type l,
                                        output dist_type r);
      int cap;
      case (mix)
         MIX_BACKWARD: begin
            f = dist_type'($urandom_range(0, 40));
            b = dist_type'($urandom_range(100, 255));
            l = dist_type'($urandom_range(0, 120));
            r = dist_type'($urandom_range(0, 120));
         end
         MIX_FORWARD: begin
            f = dist_type'($urandom_range(150, 255));
            b = dist_type'($urandom_range(0, 255));
            l = dist_type'($urandom_range(0, 255));
            r = dist_type'($urandom_range(0, 255));
         end
         MIX_SIDES: begin
            f = dist_type'($urandom_range(0, 60));
            b = dist_type'($urandom_range(0, 60));
            l = dist_type'($urandom_range(0, 255));
            r = dist_type'($urandom_range(0, 255));
         end
         MIX_EDGE: begin
            f = near_edge();
            b = near_edge();
            l = near_edge();
            r = near_edge();
         end
         MIX_BLOCKED: begin
            cap = int'(crit_q) + 1;
            if (cap > 255) cap = 255;
            f = dist_type'($urandom_range(0, cap));
            b = dist_type'($urandom_range(0, cap));
            l = dist_type'($urandom_range(0, cap));
            r = dist_type'($urandom_range(0, cap));
         end
         default: begin
            f = dist_type'($urandom_range(0, 255));
            b = dist_type'($urandom_range(0, 255));
            l = dist_type'($urandom_range(0, 255));
            r = dist_type'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Runs of one reading shape, so the history fills with repeats, backward majorities
   // and mixed moves and the stuck escape gets exercised
   task automatic send_random_runs(input int count);
      reading_mix_type mix;
      int              run;
      int              sent;
      dist_type        f;
      dist_type        b;
      dist_type        l;
      dist_type        r;
      sent = 0;
      while (sent < count) begin
         mix = reading_mix_type'($urandom_range(0, 5));
         run = $urandom_range(1, 12);
         for (int i = 0; i < run && sent < count; i++) begin
            draw_reading(mix, f, b, l, r);
            send_reading(f, b, l, r);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Stop, fallback, extremes, a forced escape with a side tie, and a diagonal win
   task automatic test_directed();
      send_reading(8'd0, 8'd0, 8'd0, 8'd0);           // boxed in: stop
      send_reading(8'd14, 8'd14, 8'd14, 8'd14);       // just under the stop limit: stop
      send_reading(8'd15, 8'd14, 8'd14, 8'd14);       // not boxed, nothing safe: fallback
      send_reading(8'd255, 8'd255, 8'd255, 8'd255);   // all open: north
      // Only the rear is open: fill the history with south until the stuck counter runs out
      repeat (11) send_reading(8'd10, 8'd255, 8'd10, 8'd10);
      send_reading(8'd50, 8'd50, 8'd90, 8'd90);       // escape, west and east tied
      // Repeated north decays its score until a diagonal wins
      repeat (5) send_reading(8'd255, 8'd0, 8'd0, 8'd0);
      send_reading(8'd100, 8'd0, 8'd0, 8'd110);
      send_reading(8'd0, 8'd0, 8'd255, 8'd0);
      send_reading(8'd0, 8'd0, 8'd0, 8'd255);
   endtask

   task automatic test_default_random();
      send_random_runs(150);
   endtask

   // Threshold and stop limit at both ends of their range
   task automatic test_register_extremes();
      apply_settings(8'd0, 8'd0);
      send_random_runs(100);
      apply_settings(8'd255, 8'd255);
      send_random_runs(60);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         apply_settings(dist_type'($urandom_range(0, 255)), dist_type'($urandom_range(0, 255)));
         send_random_runs(60);
      end
   endtask

   // Hold off the receiver for a long stretch while items keep coming, so the output
   // register fills and the block stalls its input
   task automatic test_output_backpressure();
      apply_settings(8'd40, 8'd10);
      tx_idle_en = 1'b0;
      hold_rsp_cycles = 400;
      send_random_runs(12);
      tx_idle_en = 1'b1;
      send_random_runs(80);
   endtask

   // Last stretch at full rate on both sides
   task automatic test_full_rate();
      apply_settings(8'd25, 8'd15);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      send_random_runs(150);
   endtask

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.front_distance <= '0;
      req_chan.back_distance  <= '0;
      req_chan.left_distance  <= '0;
      req_chan.right_distance <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= CSR_OBSTACLE_THRESHOLD;
      csr_chan.wdata          <= '0;
      err_count       = 0;
      hold_rsp_cycles = 0;
      tx_idle_en      = 1'b1;
      rx_idle_en      = 1'b1;
      clear_predictor();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_default_random();
      test_register_extremes();
      test_random_settings();
      test_output_backpressure();
      test_full_rate();

      // Drain everything still pending, then give the block time for stray results
      req_chan.valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("obstacle_avoid_direction_pick_tb: clean");
      else
         $display("obstacle_avoid_direction_pick_tb: errors");
      $finish;
   end

endmodule
